// File: hdl/tvp_pkg.sv
`default_nettype none
package tvp_pkg;
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_UP     = 3'd1,
      PH_CRUISE = 3'd2,
      PH_DOWN   = 3'd3,
      PH_FINAL  = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      CS_IDLE, CS_PREP, CS_MUL1, CS_MUL2, CS_CMP, CS_DIV, CS_ROOT, CS_CHK, CS_CRDIV,
      CS_DONE, CS_OUT
   } ctl_state_type;

   localparam int unsigned REG_MAX_SPEED = 0;
   localparam int unsigned REG_ACCEL     = 1;
   localparam int unsigned VEL_LIMIT     = 131071;

   typedef struct packed {
      logic load;      // latch distance
      logic prep;      // compute magnitude and effective registers
      logic mul1;      // products m*a and v*v
      logic mul2;      // product v*a and short-move comparison
      logic div_step;  // one restoring division step
      logic root_step; // one root bit
      logic sel_short; // start short-move divide (m+a-1)/a
      logic sel_ramp;  // start long-move ramp divide (v+a-1)/a
      logic sel_cruise;// start cruise divide
      logic root_fix;  // final root correction
      logic commit;    // load plan and enter first phase
      logic tick;      // advance profile by one tick
   } cmd_type;

   typedef struct packed {
      logic is_short;
      logic step_done;
      logic idle;
   } sts_type;
endpackage
`default_nettype wire

// File: hdl/tvp_ctrl.sv
`default_nettype none
module tvp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic             req_op,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire tvp_pkg::sts_type sts,
   output tvp_pkg::cmd_type      cmd
);
   tvp_pkg::ctl_state_type state_ff, state_in;
   logic ramp_done_ff, ramp_done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tvp_pkg::CS_IDLE;
         ramp_done_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ramp_done_ff <= ramp_done_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ramp_done_in = ramp_done_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      unique case (state_ff)
         tvp_pkg::CS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_op) begin
                  cmd.tick = 1'b1;
                  state_in = tvp_pkg::CS_OUT;
               end else if (sts.idle) begin
                  cmd.load = 1'b1;
                  state_in = tvp_pkg::CS_PREP;
               end
            end
         end
         tvp_pkg::CS_PREP: begin
            cmd.prep = 1'b1;
            state_in = tvp_pkg::CS_MUL1;
         end
         tvp_pkg::CS_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = tvp_pkg::CS_MUL2;
         end
         tvp_pkg::CS_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = tvp_pkg::CS_CMP;
         end
         tvp_pkg::CS_CMP: begin
            ramp_done_in = 1'b0;
            if (sts.is_short) cmd.sel_short = 1'b1;
            else              cmd.sel_ramp  = 1'b1;
            state_in = tvp_pkg::CS_DIV;
         end
         tvp_pkg::CS_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.step_done) begin
               if (sts.is_short) state_in = tvp_pkg::CS_ROOT;
               else if (!ramp_done_ff) begin
                  ramp_done_in = 1'b1;
                  state_in     = tvp_pkg::CS_CRDIV;
               end else state_in = tvp_pkg::CS_DONE;
            end
         end
         tvp_pkg::CS_CRDIV: begin
            cmd.sel_cruise = 1'b1;
            state_in = tvp_pkg::CS_DIV;
         end
         tvp_pkg::CS_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.step_done) state_in = tvp_pkg::CS_CHK;
         end
         tvp_pkg::CS_CHK: begin
            cmd.root_fix = 1'b1;
            state_in = tvp_pkg::CS_DONE;
         end
         tvp_pkg::CS_DONE: begin
            cmd.commit = 1'b1;
            state_in = tvp_pkg::CS_IDLE;
         end
         tvp_pkg::CS_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = tvp_pkg::CS_IDLE;
         end
         default: state_in = tvp_pkg::CS_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: hdl/tvp_dp.sv
`default_nettype none
module tvp_dp #(
   parameter int unsigned TICK_COUNT_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [15:0]       csr_wdata,
   input  wire logic [31:0]       req_distance,
   input  wire tvp_pkg::cmd_type  cmd,
   output tvp_pkg::sts_type       sts,
   output logic signed [17:0]     rsp_velocity,
   output logic                   rsp_active,
   output logic                   rsp_last
);
   localparam int unsigned TW = TICK_COUNT_WIDTH;
   localparam int unsigned QW = 50;
   localparam logic [QW-1:0] CNT_MAX = QW'((65'd1 << TW) - 65'd1);

   logic [15:0] max_speed_ff, accel_ff;
   logic [31:0] dist_ff;
   logic [31:0] m_ff;
   logic [1:0]  sign_ff;           // [1] negative, [0] nonzero
   logic [16:0] v_ff, a_ff;
   logic [47:0] ma_ff;
   logic [31:0] vv_ff, va_ff;
   logic        short_ff;
   logic [QW-1:0] num_ff, quo_ff, den_ff, rem_ff;
   logic [5:0]  cnt_ff;
   logic [17:0] root_ff;
   logic [QW-1:0] ramp_ff, cruise_ff, ramp_res_ff;
   tvp_pkg::phase_type phase_ff, phase_in;
   logic [TW-1:0] left_ff, left_in;
   logic signed [17:0] vel_ff, vel_in;
   logic move_neg_ff, move_nz_ff;
   logic act_ff, last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= 16'd5000;
         accel_ff     <= 16'd50;
      end else if (csr_we) begin
         if (csr_index == 1'(tvp_pkg::REG_MAX_SPEED)) max_speed_ff <= csr_wdata;
         else                                          accel_ff     <= csr_wdata;
      end
   end

   logic [QW:0] rem_try;
   logic [QW-1:0] rem_sh;
   logic [17:0] root_try;
   logic [35:0] root_sq;
   assign rem_sh   = {rem_ff[QW-2:0], num_ff[QW-1]};
   assign rem_try  = {1'b0, rem_sh} - {1'b0, den_ff};
   assign root_try = root_ff | (18'd1 << cnt_ff[4:0]);
   assign root_sq  = root_try * root_try;

   always_ff @(posedge clock) begin
      if (cmd.load) dist_ff <= req_distance;
      if (cmd.prep) begin
         sign_ff <= {dist_ff[31], dist_ff != 32'd0};
         m_ff    <= dist_ff[31] ? (~dist_ff + 32'd1) : dist_ff;
         v_ff    <= (max_speed_ff == 16'd0) ? 17'd1 : {1'b0, max_speed_ff};
         a_ff    <= (accel_ff == 16'd0) ? 17'd1 : {1'b0, accel_ff};
      end
      if (cmd.mul1) begin
         ma_ff <= m_ff * a_ff[15:0];
         vv_ff <= v_ff[15:0] * v_ff[15:0];
      end
      if (cmd.mul2) begin
         va_ff    <= v_ff[15:0] * a_ff[15:0];
         short_ff <= ma_ff <= {16'd0, vv_ff};
      end
      if (cmd.sel_short) begin
         num_ff <= QW'(m_ff) + QW'(a_ff) - QW'(1);
         den_ff <= QW'(a_ff);
         rem_ff <= '0;
         cnt_ff <= 6'(QW);
      end
      if (cmd.sel_ramp) begin
         num_ff <= QW'(v_ff) + QW'(a_ff) - QW'(1);
         den_ff <= QW'(a_ff);
         rem_ff <= '0;
         cnt_ff <= 6'(QW);
      end
      if (cmd.sel_cruise) begin
         ramp_res_ff <= quo_ff;
         num_ff <= QW'(ma_ff) - QW'(vv_ff) + QW'(va_ff) - QW'(1);
         den_ff <= QW'(va_ff);
         rem_ff <= '0;
         cnt_ff <= 6'(QW);
      end
      if (cmd.div_step) begin
         num_ff <= {num_ff[QW-2:0], 1'b0};
         if (!rem_try[QW]) begin
            rem_ff <= rem_try[QW-1:0];
            quo_ff <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[QW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            cnt_ff  <= 6'd17;
            root_ff <= '0;
         end
      end
      if (cmd.root_step) begin
         if ({14'd0, root_sq} <= quo_ff) root_ff <= root_try;
         cnt_ff <= cnt_ff - 6'd1;
      end
      if (cmd.root_fix) begin
         ramp_ff   <= (QW'(root_ff * root_ff) < quo_ff) ? QW'(root_ff) + QW'(1) : QW'(root_ff);
         cruise_ff <= '0;
      end
      if (cmd.commit && !short_ff) begin
         ramp_ff   <= ramp_res_ff;
         cruise_ff <= (quo_ff > CNT_MAX) ? CNT_MAX : quo_ff;
      end
   end

   assign sts.is_short  = short_ff;
   assign sts.step_done = cmd.root_step ? (cnt_ff == 6'd0) : (cnt_ff == 6'd1);
   assign sts.idle      = phase_ff == tvp_pkg::PH_IDLE;

   function automatic logic [16:0] a_eff();
      return (accel_ff == 16'd0) ? 17'd1 : {1'b0, accel_ff};
   endfunction
   function automatic logic [16:0] v_eff();
      return (max_speed_ff == 16'd0) ? 17'd1 : {1'b0, max_speed_ff};
   endfunction

   // Velocity step for the present tick.
   logic signed [18:0] sa, sv, vnext;
   logic [TW-1:0] ramp_n, cruise_n, dec;
   assign ramp_n   = TW'(ramp_ff);
   assign cruise_n = TW'(cruise_ff);
   always_comb begin
      sa = move_nz_ff ? (move_neg_ff ? -$signed({2'b0, a_eff()}) : $signed({2'b0, a_eff()}))
                      : 19'sd0;
      sv = move_nz_ff ? (move_neg_ff ? -$signed({2'b0, v_eff()}) : $signed({2'b0, v_eff()}))
                      : 19'sd0;
   end

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      vel_in   = vel_ff;
      vnext    = '0;
      dec      = left_ff - TW'(1);
      if (cmd.commit) begin
         vel_in = '0;
         if (!short_ff ? (TW'(ramp_res_ff) != '0) : (ramp_n != '0)) begin
            phase_in = tvp_pkg::PH_UP;
            left_in  = !short_ff ? TW'(ramp_res_ff) : ramp_n;
         end else if (!short_ff && quo_ff != '0) begin
            phase_in = tvp_pkg::PH_CRUISE;
            left_in  = TW'((quo_ff > CNT_MAX) ? CNT_MAX : quo_ff);
         end else begin
            phase_in = tvp_pkg::PH_FINAL;
            left_in  = '0;
         end
      end else if (cmd.tick) begin
         unique case (phase_ff)
            tvp_pkg::PH_UP, tvp_pkg::PH_CRUISE, tvp_pkg::PH_DOWN: begin
               if (phase_ff == tvp_pkg::PH_UP)          vnext = 19'(vel_ff) + sa;
               else if (phase_ff == tvp_pkg::PH_CRUISE) vnext = sv;
               else                                     vnext = 19'(vel_ff) - sa;
               if (vnext > 19'sd131071)       vel_in = 18'sd131071;
               else if (vnext < -19'sd131071) vel_in = -18'sd131071;
               else                           vel_in = vnext[17:0];
               left_in = dec;
               if (dec == '0) begin
                  if (phase_ff == tvp_pkg::PH_UP && cruise_n != '0) begin
                     phase_in = tvp_pkg::PH_CRUISE; left_in = cruise_n;
                  end else if (phase_ff != tvp_pkg::PH_DOWN && ramp_n != '0) begin
                     phase_in = tvp_pkg::PH_DOWN; left_in = ramp_n;
                  end else begin
                     phase_in = tvp_pkg::PH_FINAL; left_in = '0;
                  end
               end
            end
            tvp_pkg::PH_FINAL: begin
               vel_in = '0; phase_in = tvp_pkg::PH_IDLE;
            end
            default: begin
               vel_in = '0; phase_in = tvp_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= tvp_pkg::PH_IDLE;
         left_ff     <= '0;
         vel_ff      <= '0;
         move_neg_ff <= 1'b0;
         move_nz_ff  <= 1'b0;
         act_ff      <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         vel_ff   <= vel_in;
         if (cmd.commit) begin
            move_neg_ff <= sign_ff[1];
            move_nz_ff  <= sign_ff[0];
         end
         if (cmd.tick) begin
            act_ff  <= phase_ff != tvp_pkg::PH_IDLE;
            last_ff <= phase_ff == tvp_pkg::PH_FINAL;
         end
      end
   end

   assign rsp_velocity = vel_ff;
   assign rsp_active   = act_ff;
   assign rsp_last     = last_ff;
endmodule
`default_nettype wire

// File: hdl/trapezoid_velocity_profile.sv
// A tick's result is offered in the cycle after its transfer, and the next request is
// accepted in the cycle after the result transfer.
// A start runs setup plus two 50-step divisions on a long move, or setup, one 50-step
// division and 18 root steps on a short one, and gives no result.
// No request is taken until the last is done; all divides share one bit-serial divider.
// Synchronous reset: registers take 5000 and 50, profile idle, velocity zero.
`default_nettype none
module trapezoid_velocity_profile #(
   parameter int unsigned TICK_COUNT_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // distance
   input  wire logic        req_tuser,  // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // velocity[17:0], active, last, zero fill
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   tvp_pkg::cmd_type cmd;
   tvp_pkg::sts_type sts;
   logic signed [17:0] vel;
   logic act, lst;

   tvp_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_op(req_tuser),
      .rsp_tvalid, .rsp_tready, .sts, .cmd
   );

   tvp_dp #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_dp (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_distance(req_tdata), .cmd, .sts,
      .rsp_velocity(vel), .rsp_active(act), .rsp_last(lst)
   );

   assign rsp_tdata = {4'd0, lst, act, vel};
endmodule
`default_nettype wire
